// ----- hdl/plc_pkg.sv -----
// Package: shared types and constants of the power-law index clamp.
package plc_pkg;

    // Fixed widths of the index fields and the configuration port
    localparam int IDX_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX = 2'd1;

    // Reset values of the clamp limits
    localparam logic signed [IDX_W-1:0] MIN_INDEX_RST = 24'sh800000;
    localparam logic signed [IDX_W-1:0] MAX_INDEX_RST = 24'sh7FFFFF;

    // Side information travelling with each item down the pipeline
    typedef struct packed {
        logic                    valid;
        logic                    bg;
        logic                    invalid;
        logic                    neg;
        logic signed [IDX_W-1:0] dflt;
    } t_side;

    // One result item
    typedef struct packed {
        logic signed [IDX_W-1:0] index;
        logic signed [IDX_W-1:0] one_minus_index;
        logic                    limited;
        logic                    invalid;
    } t_result;

endpackage

// ----- hdl/plc_if.sv -----
// Interfaces: input item, result item and configuration write channels.
interface plc_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [VALUE_WIDTH-1:0]        flux_low;
    logic [VALUE_WIDTH-1:0]        flux_high;
    logic [VALUE_WIDTH-1:0]        energy_low;
    logic [VALUE_WIDTH-1:0]        energy_high;
    logic                          is_background;
    logic signed [plc_pkg::IDX_W-1:0] default_index;

    modport source (output valid, flux_low, flux_high, energy_low, energy_high,
                    is_background, default_index, input ready);
    modport sink   (input valid, flux_low, flux_high, energy_low, energy_high,
                    is_background, default_index, output ready);
endinterface

interface plc_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [plc_pkg::IDX_W-1:0] index;
    logic signed [plc_pkg::IDX_W-1:0] one_minus_index;
    logic                          limited;
    logic                          invalid;

    modport source (output valid, index, one_minus_index, limited, invalid, input ready);
    modport sink   (input valid, index, one_minus_index, limited, invalid, output ready);
endinterface

interface plc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [plc_pkg::CFG_IDX_W-1:0]     index;
    logic [plc_pkg::IDX_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/power_law_index_clamp.sv -----
// Top level: power-law spectral index of a channel pair, clamped to limits.
// One channel pair is accepted per clock cycle while the result side takes
// results. QW = clog2(VALUE_WIDTH) + 2*FRAC_BITS (37 for the defaults) is the
// quotient width; the pipeline has one squaring stage per logarithm fraction
// bit and one divider stage per quotient bit.
// The whole pipeline holds while a finished result is not taken. Limits are
// written through the configuration channel, index 0 the lower and index 1
// the upper limit, signed with FRAC_BITS fraction bits; other indexes are
// ignored. Invalid items (zero flux or energy, equal energies) and background
// items give the default index unclamped.
module power_law_index_clamp #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_in_if.sink    i_in,
    plc_out_if.source o_out,
    plc_cfg_if.sink   i_cfg
);
    import plc_pkg::*;

    localparam int PW     = $clog2(VALUE_WIDTH);
    localparam int LW     = PW + FRAC_BITS;
    localparam int QW     = LW + FRAC_BITS;
    localparam int NSTAGE = FRAC_BITS + QW + 3;
    localparam int CW     = (QW + 1 > IDX_W + 1) ? QW + 1 : IDX_W + 1;
    localparam int OW     = IDX_W + 3;

    logic en;
    logic signed [IDX_W-1:0] r_min, r_max;
    t_side   r_side [0:NSTAGE-1];
    t_result r_out;
    logic    r_ov;

    logic [LW-1:0] log_fl, log_fh, log_el, log_eh;
    logic [LW-1:0] r_nm, r_dm;
    logic [QW-1:0] quot;

    // pipeline advances when the output register is free
    assign en          = !r_ov || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_INDEX_RST;
            r_max <= MAX_INDEX_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_MIN_INDEX) begin
                r_min <= i_cfg.data;
            end else if (i_cfg.index == REG_MAX_INDEX) begin
                r_max <= i_cfg.data;
            end
        end
    end

    // four logarithm lanes
    plc_log #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_fl (
        .i_clk(i_clk), .i_en(en), .i_x(i_in.flux_low), .o_log(log_fl));
    plc_log #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_fh (
        .i_clk(i_clk), .i_en(en), .i_x(i_in.flux_high), .o_log(log_fh));
    plc_log #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_el (
        .i_clk(i_clk), .i_en(en), .i_x(i_in.energy_low), .o_log(log_el));
    plc_log #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_log_eh (
        .i_clk(i_clk), .i_en(en), .i_x(i_in.energy_high), .o_log(log_eh));

    // side information shift line
    t_side n_side0;
    always_comb begin
        n_side0.valid   = i_in.valid;
        n_side0.bg      = i_in.is_background;
        n_side0.invalid = (i_in.flux_low == '0) || (i_in.flux_high == '0) ||
                          (i_in.energy_low == '0) || (i_in.energy_high == '0) ||
                          (i_in.energy_low == i_in.energy_high);
        n_side0.neg     = 1'b0;
        n_side0.dflt    = i_in.default_index;
    end

    // log differences, signs and magnitudes
    logic signed [LW:0] num, den;
    logic [LW:0] num_mag, den_mag;
    t_side n_sided;
    always_comb begin
        num     = $signed({1'b0, log_fl}) - $signed({1'b0, log_fh});
        den     = $signed({1'b0, log_eh}) - $signed({1'b0, log_el});
        num_mag = num[LW] ? -num : num;
        den_mag = den[LW] ? -den : den;
        n_sided = r_side[FRAC_BITS];
        n_sided.neg = num[LW] ^ den[LW];
        if (den == '0) begin
            n_sided.invalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTAGE; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < NSTAGE; k++) begin
                r_side[k] <= (k == FRAC_BITS + 1) ? n_sided : r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm <= num_mag[LW-1:0];
            r_dm <= den_mag[LW-1:0];
        end
    end

    plc_div #(.LW(LW), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_en(en), .i_num(r_nm), .i_den(r_dm), .o_quot(quot));

    // clamp, default selection and one minus index
    logic signed [CW-1:0] q, lo, hi;
    logic signed [OW-1:0] omi;
    t_side   sl;
    t_result n_out;
    always_comb begin
        sl = r_side[NSTAGE-1];
        q  = sl.neg ? -$signed({{(CW-QW){1'b0}}, quot}) : $signed({{(CW-QW){1'b0}}, quot});
        lo = CW'(r_min);
        hi = CW'(r_max);
        n_out.invalid = sl.invalid;
        n_out.limited = 1'b0;
        n_out.index   = sl.dflt;
        if (!sl.invalid && !sl.bg) begin
            if (q < lo) begin
                n_out.index   = r_min;
                n_out.limited = 1'b1;
            end else if (q > hi) begin
                n_out.index   = r_max;
                n_out.limited = 1'b1;
            end else begin
                n_out.index   = q[IDX_W-1:0];
            end
        end
        omi = (OW'(1) <<< FRAC_BITS) - OW'(n_out.index);
        if (omi > OW'(MAX_INDEX_RST)) begin
            n_out.one_minus_index = MAX_INDEX_RST;
        end else if (omi < OW'(MIN_INDEX_RST)) begin
            n_out.one_minus_index = MIN_INDEX_RST;
        end else begin
            n_out.one_minus_index = omi[IDX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= sl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.index           = r_out.index;
    assign o_out.one_minus_index = r_out.one_minus_index;
    assign o_out.limited         = r_out.limited;
    assign o_out.invalid         = r_out.invalid;
endmodule

// ----- hdl/plc_log.sv -----
// Pipelined truncated base-2 logarithm: normalise, then one squaring per stage.
module plc_log #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int PW          = $clog2(VALUE_WIDTH),
    parameter int LW          = PW + FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [VALUE_WIDTH-1:0] i_x,
    output logic [LW-1:0]          o_log
);
    logic [PW-1:0]             n_p;
    logic [VALUE_WIDTH+29:0]   n_wide;

    logic [30:0]          r_m [0:FRAC_BITS];
    logic [PW-1:0]        r_p [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_f [0:FRAC_BITS];

    // leading one position
    always_comb begin
        n_p = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (i_x[i]) begin
                n_p = PW'(i);
            end
        end
        n_wide = {i_x, 30'b0} >> n_p;
    end

    // normalised Q1.30 mantissa
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_wide[30:0];
            r_p[0] <= n_p;
            r_f[0] <= '0;
        end
    end

    // one fraction bit per stage
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] t;
        assign sq = {31'b0, r_m[k-1]} * {31'b0, r_m[k-1]};
        assign t  = sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= t[31] ? t[31:1] : t[30:0];
                r_p[k] <= r_p[k-1];
                r_f[k] <= {r_f[k-1][FRAC_BITS-2:0], t[31]};
            end
        end
    end

    assign o_log = {r_p[FRAC_BITS], r_f[FRAC_BITS]};
endmodule

// ----- hdl/plc_div.sv -----
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
module plc_div #(
    parameter int LW        = 21,
    parameter int FRAC_BITS = 16,
    parameter int QW        = LW + FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [LW-1:0] i_num,
    input  logic [LW-1:0] i_den,
    output logic [QW-1:0] o_quot
);
    logic [LW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_dq  [0:QW];
    logic [LW-1:0] r_d   [0:QW];

    // load scaled dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= {i_num, {FRAC_BITS{1'b0}}};
            r_d[0]   <= i_den;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [LW:0] t;
        logic [LW:0] diff;
        logic        ge;
        assign t    = {r_rem[k-1], r_dq[k-1][QW-1]};
        assign diff = t - {1'b0, r_d[k-1]};
        assign ge   = t >= {1'b0, r_d[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[LW-1:0] : t[LW-1:0];
                r_dq[k]  <= {r_dq[k-1][QW-2:0], ge};
                r_d[k]   <= r_d[k-1];
            end
        end
    end

    assign o_quot = r_dq[QW];
endmodule

// ----- hdl/plc_checker.sv -----
// Checker: port-level properties of the power-law index clamp, and its bind.
module plc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_limited,
    input logic i_out_invalid
);
    // a pending result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result blocks new transactions
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted during output stall");

    // invalid results are never clamped
    a_inv_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_invalid |-> !i_out_limited)
        else $error("invalid result flagged as limited");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind power_law_index_clamp plc_checker u_plc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_limited(o_out.limited),
    .i_out_invalid(o_out.invalid)
);

// ----- tb/sv/plc_index_checker.sv -----
// Checker: predicts the clamped power-law index and compares each result transaction.
module plc_index_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    plc_in_if    in_ch,
    plc_out_if   out_ch,
    plc_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import plc_pkg::*;

    localparam int      FRAC = 16;
    localparam longint  ONE_Q = longint'(1) << FRAC;
    localparam longint  IDX_MAX = 8388607;
    localparam longint  IDX_MIN = -8388608;

    logic signed [IDX_W-1:0] lower_limit;
    logic signed [IDX_W-1:0] upper_limit;
    t_result                 expected_results[$];
    int                      mismatches;

    // Truncated base-2 logarithm with FRAC fraction bits
    function automatic longint log2_q(longint unsigned x);
        int              p;
        int              i;
        longint unsigned m;
        longint unsigned r;
        p = 63;
        while (p > 0 && !x[p]) p--;
        if (p >= 30) m = x >> (p - 30);
        else m = x << (30 - p);
        r = longint'(p);
        for (i = 0; i < FRAC; i++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31)) begin
                r = r | 64'd1;
                m = m >> 1;
            end
        end
        return longint'(r);
    endfunction

    // Expected result of one channel pair under the current limits
    function automatic t_result predict_index(logic [31:0] fl, logic [31:0] fh,
                                              logic [31:0] el, logic [31:0] eh,
                                              logic bg, logic signed [IDX_W-1:0] dflt);
        t_result res;
        longint  num;
        longint  den;
        longint  q;
        longint  idx;
        longint  omi;
        logic    bad;
        logic    clamped;
        num = 0;
        den = 0;
        bad = 1'b0;
        clamped = 1'b0;
        idx = longint'(dflt);
        if (fl == 0 || fh == 0 || el == 0 || eh == 0 || el == eh) begin
            bad = 1'b1;
        end else begin
            num = log2_q(fl) - log2_q(fh);
            den = log2_q(eh) - log2_q(el);
            if (den == 0) bad = 1'b1;
        end
        if (!bad && !bg) begin
            q = (num * ONE_Q) / den;
            if (q < longint'(lower_limit)) begin
                q = longint'(lower_limit);
                clamped = 1'b1;
            end else if (q > longint'(upper_limit)) begin
                q = longint'(upper_limit);
                clamped = 1'b1;
            end
            idx = q;
        end
        omi = ONE_Q - idx;
        if (omi > IDX_MAX) omi = IDX_MAX;
        if (omi < IDX_MIN) omi = IDX_MIN;
        res.index           = idx[IDX_W-1:0];
        res.one_minus_index = omi[IDX_W-1:0];
        res.limited         = clamped;
        res.invalid         = bad;
        return res;
    endfunction

    // Watch the three channels at each rising edge
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            lower_limit <= MIN_INDEX_RST;
            upper_limit <= MAX_INDEX_RST;
            expected_results.delete();
            mismatches = 0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_MIN_INDEX) lower_limit <= cfg_ch.data;
                else if (cfg_ch.index == REG_MAX_INDEX) upper_limit <= cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(predict_index(in_ch.flux_low, in_ch.flux_high,
                    in_ch.energy_low, in_ch.energy_high, in_ch.is_background,
                    in_ch.default_index));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: index %0d", out_ch.index);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.index !== exp_r.index
                        || out_ch.one_minus_index !== exp_r.one_minus_index
                        || out_ch.limited !== exp_r.limited
                        || out_ch.invalid !== exp_r.invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "mismatch: idx %0d/%0d omi %0d/%0d lim %b/%b inv %b/%b (exp/act)",
                                exp_r.index, out_ch.index, exp_r.one_minus_index,
                                out_ch.one_minus_index, exp_r.limited, out_ch.limited,
                                exp_r.invalid, out_ch.invalid);
                    end
                end
            end
            o_fail_count <= mismatches;
            o_pending    <= expected_results.size();
        end
    end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, stimulus for the power-law index clamp and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    logic no_gaps;
    int   ready_hold;

    plc_in_if #(.VALUE_WIDTH(32)) in_ch ();
    plc_out_if                    out_ch ();
    plc_cfg_if                    cfg_ch ();

    power_law_index_clamp #(.VALUE_WIDTH(32), .FRAC_BITS(16)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    plc_index_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_ch      (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("power_law_index_clamp verification failed");
            $finish;
        end
    end

    // Result side back-pressure: bursts of ready, short stalls, a few long ones
    initial begin
        out_ch.ready = 1'b0;
        ready_hold = 0;
    end
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 11))
                0: begin
                    out_ch.ready <= 1'b0;
                    ready_hold   <= $urandom_range(20, 60);
                end
                1, 2, 3: begin
                    out_ch.ready <= 1'b0;
                    ready_hold   <= $urandom_range(0, 3);
                end
                default: begin
                    out_ch.ready <= 1'b1;
                    ready_hold   <= $urandom_range(0, 40);
                end
            endcase
        end
    end

    // Sender gap: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Operand with varied magnitude
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(1, 1000);
            2: return $urandom() >> $urandom_range(0, 31);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            4: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom() | 32'd1;
        endcase
    endfunction

    task automatic send_pair(logic [31:0] fl, logic [31:0] fh, logic [31:0] el,
                             logic [31:0] eh, logic bg, logic [IDX_W-1:0] dflt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.flux_low      <= fl;
        in_ch.flux_high     <= fh;
        in_ch.energy_low    <= el;
        in_ch.energy_high   <= eh;
        in_ch.is_background <= bg;
        in_ch.default_index <= dflt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Wait for every outstanding result, then let the pipeline empty
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
        write_reg(REG_MIN_INDEX, lo);
        write_reg(REG_MAX_INDEX, hi);
        write_reg(REG_SPARE, IDX_W'($urandom()));
    endtask

    // Random phase: mostly well-formed pairs, some degenerate ones
    task automatic random_phase(int n);
        logic [31:0] fl, fh, el, eh;
        int          k;
        for (k = 0; k < n; k++) begin
            fl = pick_value();
            fh = pick_value();
            el = pick_value();
            eh = pick_value();
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 5))
                    0: fl = '0;
                    1: fh = '0;
                    2: el = '0;
                    3: eh = '0;
                    4: eh = el;
                    default: eh = el + 1;
                endcase
            end else begin
                if (fl == 0) fl = 1;
                if (fh == 0) fh = 1;
                if (el == 0) el = 1;
                if (eh == 0) eh = 2;
            end
            send_pair(fl, fh, el, eh, ($urandom_range(0, 6) == 0), IDX_W'($urandom()));
            if (k == n / 2 && n > 100) begin
                drain();
            end
        end
    endtask

    // Stimulus
    initial begin
        int ph;
        i_rst_n             <= 1'b0;
        no_gaps             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.flux_low      <= '0;
        in_ch.flux_high     <= '0;
        in_ch.energy_low    <= '0;
        in_ch.energy_high   <= '0;
        in_ch.is_background <= 1'b0;
        in_ch.default_index <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed items under reset limits
        send_pair(32'd0, 32'd5, 32'd10, 32'd20, 1'b0, 24'h012345);        // zero flux
        send_pair(32'd5, 32'd0, 32'd10, 32'd20, 1'b0, 24'h800000);
        send_pair(32'd5, 32'd3, 32'd0, 32'd20, 1'b0, 24'h7FFFFF);         // zero energy
        send_pair(32'd5, 32'd3, 32'd20, 32'd0, 1'b1, 24'hFFFFFF);
        send_pair(32'd9, 32'd3, 32'd77, 32'd77, 1'b0, 24'h000001);        // equal energies
        send_pair(32'd9, 32'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 24'h3A5C00); // close energies
        send_pair(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd2, 1'b0, 24'h0);       // steep positive
        send_pair(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd2, 1'b0, 24'h0);       // steep negative
        send_pair(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 24'h0);
        send_pair(32'd1000, 32'd10, 32'd10, 32'd100, 1'b0, 24'h0);
        send_pair(32'd1000, 32'd10, 32'd10, 32'd100, 1'b1, 24'h7FFFFF);   // background
        send_pair(32'd1000, 32'd10, 32'd10, 32'd100, 1'b1, 24'h800000);
        send_pair(32'd12345, 32'd12345, 32'd3, 32'd9, 1'b0, 24'h0);       // flat spectrum
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 24'h0);
        drain();

        // Phases with different limits, extremes included
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_limits(24'h000000, 24'h020000);
                1: set_limits(24'h7FFFFF, 24'h800000);
                2: set_limits(-24'sd65536, 24'sd196608);
                3: set_limits(24'h800000, 24'h7FFFFF);
                4: set_limits(24'h010000, 24'h010000);
                default: set_limits(IDX_W'($urandom()), IDX_W'($urandom()));
            endcase
            if (ph == 1) begin
                send_pair(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd2, 1'b0, 24'h0);
                send_pair(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd2, 1'b0, 24'h0);
            end
            no_gaps <= (ph == 2);
            random_phase(330);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("power_law_index_clamp verification clean");
        end else begin
            $display("power_law_index_clamp verification failed");
        end
        $finish;
    end
endmodule

// ----- power_law_index_clamp.f -----
hdl/plc_pkg.sv
hdl/plc_if.sv
hdl/plc_log.sv
hdl/plc_div.sv
hdl/power_law_index_clamp.sv
hdl/plc_checker.sv
tb/sv/plc_index_checker.sv
tb/sv/tb.sv
